[rtl/egsp_pkg.sv]
// Shared types and constants for the euclidean graph shortest path unit.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package egsp_pkg;

    localparam int FUNC_W   = 2;
    localparam int NODE_W   = 11;
    localparam int COORD_W  = 16;
    localparam int DIST_W   = 36;
    localparam int CFG_W    = 11;
    localparam int NCMP_W   = 17;
    localparam int SQ_W     = 34;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POINT = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_E_RD,
        S_E_MX,
        S_E_MY,
        S_E_SUM,
        S_E_ROOT,
        S_Q_INIT,
        S_Q_SEED,
        S_Q_POP,
        S_Q_POP2,
        S_SD_RD,
        S_SD_CMP,
        S_Q_CHK,
        S_Q_CHK2,
        S_E_FETCH,
        S_E_TGT,
        S_E_RELAX,
        S_PU_RD,
        S_PU_CMP,
        S_Q_DONE
    } t_state;

endpackage

[rtl/egsp_if.sv]
// Request and response channel interfaces for the shortest path unit.
// Depends on egsp_pkg for field widths.
`timescale 1ns / 1ps

interface egsp_req_if;
    logic                                valid;
    logic                                ready;
    logic [egsp_pkg::FUNC_W-1:0]         func;
    logic [egsp_pkg::NODE_W-1:0]         node_a;
    logic [egsp_pkg::NODE_W-1:0]         node_b;
    logic signed [egsp_pkg::COORD_W-1:0] coord_x;
    logic signed [egsp_pkg::COORD_W-1:0] coord_y;

    modport source (output valid, func, node_a, node_b, coord_x, coord_y, input ready);
    modport sink   (input valid, func, node_a, node_b, coord_x, coord_y, output ready);
endinterface

interface egsp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [egsp_pkg::DIST_W-1:0] distance;
    logic                        unreachable;

    modport source (output valid, distance, unreachable, input ready);
    modport sink   (input valid, distance, unreachable, output ready);
endinterface

[rtl/euclidean_graph_shortest_path_unit.sv]
// Shortest path unit: loads points and directed edges, answers distance queries
// with Dijkstra over a binary heap. A point load writes the point memory on
// acceptance. An edge load reads both points, squares and sums the deltas and
// waits on the bit-serial square root. A clear and the pass after reset sweep
// all MAX_NODES list heads, with no transaction accepted meanwhile. A query
// clears the per-node state of the nodes in use, then pops the heap, visits
// the edges of each node it settles and sifts up each relaxed entry. Results
// wait in an output register.
`timescale 1ns / 1ps

module euclidean_graph_shortest_path_unit #(
    parameter int MAX_NODES = egsp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = egsp_pkg::MAX_EDGES_DEF,
    parameter int FRAC_BITS = egsp_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [egsp_pkg::CFG_W-1:0] i_cfg_data,
    egsp_req_if.sink                   i_req,
    egsp_rsp_if.source                 o_rsp
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int HCW = ECW + 1;
    localparam int LW  = 17 + FRAC_BITS;
    localparam int DW  = egsp_pkg::DIST_W;
    localparam int NCW = egsp_pkg::NCMP_W;
    localparam int EDW = ECW + NAW + LW;
    localparam int HEW = DW + NAW;
    localparam int NSW = DW + 2;
    localparam logic [NCW-1:0] NODE_LIM = NCW'(MAX_NODES);

    egsp_pkg::t_state r_state, n_state;

    // memories
    logic [31:0]    r_pt_mem [MAX_NODES];
    logic [ECW-1:0] r_lh_mem [MAX_NODES];
    logic [EDW-1:0] r_ed_mem [MAX_EDGES];
    logic [NSW-1:0] r_ns_mem [MAX_NODES];
    logic [HEW-1:0] r_hp_mem [MAX_EDGES];

    logic [31:0]    r_pt_rda, r_pt_rdb;
    logic [ECW-1:0] r_lh_rd;
    logic [EDW-1:0] r_ed_rd;
    logic [NSW-1:0] r_ns_rd;
    logic [HEW-1:0] r_hp_rda, r_hp_rdb;

    logic           pt_we, pt_re;
    logic [NAW-1:0] pt_wa, pt_raa, pt_rab;
    logic           lh_we, lh_re;
    logic [NAW-1:0] lh_wa, lh_ra;
    logic [ECW-1:0] lh_wd;
    logic           ed_we, ed_re;
    logic [EAW-1:0] ed_wa, ed_ra;
    logic [EDW-1:0] ed_wd;
    logic           ns_we, ns_re;
    logic [NAW-1:0] ns_wa, ns_ra;
    logic [NSW-1:0] ns_wd;
    logic           hp_we, hp_re;
    logic [EAW-1:0] hp_wa, hp_raa, hp_rab;
    logic [HEW-1:0] hp_wd;

    // registers
    logic [egsp_pkg::CFG_W-1:0] r_node_count;
    logic [NAW-1:0] r_cnt, n_cnt;
    logic [ECW-1:0] r_edge_count, n_edge_count;
    logic [ECW-1:0] r_heap_size, n_heap_size;
    logic [NAW-1:0] r_a, n_a, r_b, n_b;
    logic signed [16:0] r_dx, n_dx, r_dy, n_dy;
    logic [egsp_pkg::SQ_W-1:0] r_prod, n_prod, r_sq, n_sq;
    logic [DW-1:0]  r_top_dist, n_top_dist;
    logic [NAW-1:0] r_top_node, n_top_node;
    logic [HEW-1:0] r_last, n_last;
    logic [EAW-1:0] r_hi, n_hi;
    logic [ECW-1:0] r_e, n_e;
    logic [DW-1:0]  r_nd, n_nd;
    logic [NAW-1:0] r_nv, n_nv;
    logic [DW-1:0]  r_res_dist, n_res_dist;
    logic           r_res_unr, n_res_unr;
    logic           r_out_valid, n_out_valid;
    logic [DW-1:0]  r_out_dist, n_out_dist;
    logic           r_out_unr, n_out_unr;

    // combinational helpers
    logic           accept;
    egsp_pkg::t_func req_func;
    logic [NCW-1:0] a_ext, b_ext, a_m1, b_m1, n_lim;
    logic [NAW-1:0] a_idx, b_idx;
    logic           a_pt_ok, b_pt_ok, a_q_ok, b_q_ok;
    logic signed [16:0] mul_op;
    logic signed [33:0] mul_res;
    logic           sq_start, sq_done;
    logic [LW-1:0]  sq_root;
    logic [ECW-1:0] size_m1, e_m1, ed_next;
    logic [NAW-1:0] ed_tgt;
    logic [LW-1:0]  ed_len;
    logic [HCW-1:0] c_idx, c1_idx, size_ext;
    logic [EAW-1:0] p_idx;
    logic           pick_b;
    logic [HEW-1:0] pick;
    logic [DW:0]    sum_ext;
    logic [DW-1:0]  relax_d;
    logic           ns_fin, ns_reach;
    logic [DW-1:0]  ns_best;

    assign accept   = i_req.valid && i_req.ready;
    assign req_func = egsp_pkg::t_func'(i_req.func);
    assign a_ext    = NCW'(i_req.node_a);
    assign b_ext    = NCW'(i_req.node_b);
    assign a_m1     = a_ext - NCW'(1);
    assign b_m1     = b_ext - NCW'(1);
    assign a_idx    = a_m1[NAW-1:0];
    assign b_idx    = b_m1[NAW-1:0];
    assign n_lim    = (NCW'(r_node_count) > NODE_LIM) ? NODE_LIM : NCW'(r_node_count);
    assign a_pt_ok  = (a_ext != '0) && (a_ext <= NODE_LIM);
    assign b_pt_ok  = (b_ext != '0) && (b_ext <= NODE_LIM);
    assign a_q_ok   = (a_ext != '0) && (a_ext <= n_lim);
    assign b_q_ok   = (b_ext != '0) && (b_ext <= n_lim);

    assign mul_op   = (r_state == egsp_pkg::S_E_MX) ? r_dx : r_dy;
    assign mul_res  = mul_op * mul_op;

    assign size_m1  = r_heap_size - ECW'(1);
    assign e_m1     = r_e - ECW'(1);
    assign ed_next  = r_ed_rd[EDW-1 -: ECW];
    assign ed_tgt   = r_ed_rd[LW +: NAW];
    assign ed_len   = r_ed_rd[LW-1:0];
    assign size_ext = HCW'(r_heap_size);
    assign c_idx    = (HCW'(r_hi) << 1) + HCW'(1);
    assign c1_idx   = c_idx + HCW'(1);
    assign p_idx    = EAW'((r_hi - EAW'(1)) >> 1);
    assign pick_b   = (c1_idx < size_ext) &&
                      (r_hp_rdb[HEW-1 -: DW] < r_hp_rda[HEW-1 -: DW]);
    assign pick     = pick_b ? r_hp_rdb : r_hp_rda;
    assign sum_ext  = {1'b0, r_top_dist} + (DW + 1)'(ed_len);
    assign relax_d  = sum_ext[DW] ? egsp_pkg::DIST_MAX : sum_ext[DW-1:0];
    assign ns_fin   = r_ns_rd[NSW-1];
    assign ns_reach = r_ns_rd[NSW-2];
    assign ns_best  = r_ns_rd[DW-1:0];

    egsp_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_sq    (r_sq + r_prod),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_edge_count = r_edge_count;
        n_heap_size  = r_heap_size;
        n_a          = r_a;
        n_b          = r_b;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_prod       = r_prod;
        n_sq         = r_sq;
        n_top_dist   = r_top_dist;
        n_top_node   = r_top_node;
        n_last       = r_last;
        n_hi         = r_hi;
        n_e          = r_e;
        n_nd         = r_nd;
        n_nv         = r_nv;
        n_res_dist   = r_res_dist;
        n_res_unr    = r_res_unr;
        n_out_valid  = (r_out_valid && o_rsp.ready) ? 1'b0 : r_out_valid;
        n_out_dist   = r_out_dist;
        n_out_unr    = r_out_unr;
        sq_start     = 1'b0;
        i_req.ready  = 1'b0;
        pt_we  = 1'b0; pt_wa = a_idx; pt_re = 1'b0; pt_raa = a_idx; pt_rab = b_idx;
        lh_we  = 1'b0; lh_wa = r_cnt; lh_wd = '0; lh_re = 1'b0; lh_ra = r_top_node;
        ed_we  = 1'b0; ed_wa = r_edge_count[EAW-1:0]; ed_re = 1'b0;
        ed_ra  = e_m1[EAW-1:0];
        ed_wd  = {r_lh_rd, r_b, sq_root};
        ns_we  = 1'b0; ns_wa = r_cnt; ns_wd = '0; ns_re = 1'b0; ns_ra = r_top_node;
        hp_we  = 1'b0; hp_wa = r_hi; hp_wd = r_last; hp_re = 1'b0;
        hp_raa = '0; hp_rab = size_m1[EAW-1:0];

        unique case (r_state)
            egsp_pkg::S_CLR: begin
                lh_we = 1'b1;
                n_cnt = r_cnt + NAW'(1);
                if (r_cnt == NAW'(MAX_NODES - 1)) begin
                    n_state = egsp_pkg::S_IDLE;
                end
            end
            egsp_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_a = a_idx;
                    n_b = b_idx;
                    unique case (req_func)
                        egsp_pkg::FUNC_POINT: begin
                            pt_we = a_pt_ok;
                        end
                        egsp_pkg::FUNC_EDGE: begin
                            if (a_pt_ok && b_pt_ok && (r_edge_count < ECW'(MAX_EDGES))) begin
                                pt_re   = 1'b1;
                                lh_re   = 1'b1;
                                lh_ra   = a_idx;
                                n_state = egsp_pkg::S_E_RD;
                            end
                        end
                        egsp_pkg::FUNC_QUERY: begin
                            n_cnt = '0;
                            if (a_q_ok && b_q_ok) begin
                                n_state = egsp_pkg::S_Q_INIT;
                            end else begin
                                n_res_dist = '0;
                                n_res_unr  = 1'b1;
                                n_state    = egsp_pkg::S_Q_DONE;
                            end
                        end
                        egsp_pkg::FUNC_CLEAR: begin
                            n_edge_count = '0;
                            n_cnt        = '0;
                            n_state      = egsp_pkg::S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            egsp_pkg::S_E_RD: begin
                n_dx = $signed({r_pt_rda[31], r_pt_rda[31:16]}) -
                       $signed({r_pt_rdb[31], r_pt_rdb[31:16]});
                n_dy = $signed({r_pt_rda[15], r_pt_rda[15:0]}) -
                       $signed({r_pt_rdb[15], r_pt_rdb[15:0]});
                n_state = egsp_pkg::S_E_MX;
            end
            egsp_pkg::S_E_MX: begin
                n_prod  = $unsigned(mul_res);
                n_state = egsp_pkg::S_E_MY;
            end
            egsp_pkg::S_E_MY: begin
                n_sq    = r_prod;
                n_prod  = $unsigned(mul_res);
                n_state = egsp_pkg::S_E_SUM;
            end
            egsp_pkg::S_E_SUM: begin
                sq_start = 1'b1;
                n_state  = egsp_pkg::S_E_ROOT;
            end
            egsp_pkg::S_E_ROOT: begin
                if (sq_done) begin
                    ed_we        = 1'b1;
                    lh_we        = 1'b1;
                    lh_wa        = r_a;
                    lh_wd        = r_edge_count + ECW'(1);
                    n_edge_count = r_edge_count + ECW'(1);
                    n_state      = egsp_pkg::S_IDLE;
                end
            end
            egsp_pkg::S_Q_INIT: begin
                ns_we = 1'b1;
                n_cnt = r_cnt + NAW'(1);
                if (NCW'(r_cnt) == n_lim - NCW'(1)) begin
                    n_state = egsp_pkg::S_Q_SEED;
                end
            end
            egsp_pkg::S_Q_SEED: begin
                ns_we       = 1'b1;
                ns_wa       = r_a;
                ns_wd       = {1'b0, 1'b1, {DW{1'b0}}};
                hp_we       = 1'b1;
                hp_wa       = '0;
                hp_wd       = {{DW{1'b0}}, r_a};
                n_heap_size = ECW'(1);
                n_state     = egsp_pkg::S_Q_POP;
            end
            egsp_pkg::S_Q_POP: begin
                if (r_heap_size == '0) begin
                    n_res_dist = '0;
                    n_res_unr  = 1'b1;
                    n_state    = egsp_pkg::S_Q_DONE;
                end else begin
                    hp_re       = 1'b1;
                    n_heap_size = size_m1;
                    n_state     = egsp_pkg::S_Q_POP2;
                end
            end
            egsp_pkg::S_Q_POP2: begin
                n_top_dist = r_hp_rda[HEW-1 -: DW];
                n_top_node = r_hp_rda[NAW-1:0];
                n_last     = r_hp_rdb;
                n_hi       = '0;
                n_state    = egsp_pkg::S_SD_RD;
            end
            egsp_pkg::S_SD_RD: begin
                if (c_idx >= size_ext) begin
                    hp_we   = (r_heap_size != '0);
                    n_state = egsp_pkg::S_Q_CHK;
                end else begin
                    hp_re   = 1'b1;
                    hp_raa  = c_idx[EAW-1:0];
                    hp_rab  = c1_idx[EAW-1:0];
                    n_state = egsp_pkg::S_SD_CMP;
                end
            end
            egsp_pkg::S_SD_CMP: begin
                hp_we = 1'b1;
                if (r_last[HEW-1 -: DW] <= pick[HEW-1 -: DW]) begin
                    n_state = egsp_pkg::S_Q_CHK;
                end else begin
                    hp_wd   = pick;
                    n_hi    = pick_b ? c1_idx[EAW-1:0] : c_idx[EAW-1:0];
                    n_state = egsp_pkg::S_SD_RD;
                end
            end
            egsp_pkg::S_Q_CHK: begin
                ns_re   = 1'b1;
                lh_re   = 1'b1;
                n_state = egsp_pkg::S_Q_CHK2;
            end
            egsp_pkg::S_Q_CHK2: begin
                if (ns_fin) begin
                    n_state = egsp_pkg::S_Q_POP;
                end else begin
                    ns_we = 1'b1;
                    ns_wa = r_top_node;
                    ns_wd = {1'b1, ns_reach, ns_best};
                    if (r_top_node == r_b) begin
                        n_res_dist = r_top_dist;
                        n_res_unr  = 1'b0;
                        n_state    = egsp_pkg::S_Q_DONE;
                    end else if (r_lh_rd == '0) begin
                        n_state = egsp_pkg::S_Q_POP;
                    end else begin
                        n_e     = r_lh_rd;
                        n_state = egsp_pkg::S_E_FETCH;
                    end
                end
            end
            egsp_pkg::S_E_FETCH: begin
                ed_re   = 1'b1;
                n_state = egsp_pkg::S_E_TGT;
            end
            egsp_pkg::S_E_TGT: begin
                if (NCW'(ed_tgt) >= n_lim) begin
                    n_e     = ed_next;
                    n_state = (ed_next == '0) ? egsp_pkg::S_Q_POP : egsp_pkg::S_E_FETCH;
                end else begin
                    ns_re   = 1'b1;
                    ns_ra   = ed_tgt;
                    n_state = egsp_pkg::S_E_RELAX;
                end
            end
            egsp_pkg::S_E_RELAX: begin
                n_e     = ed_next;
                n_state = (ed_next == '0) ? egsp_pkg::S_Q_POP : egsp_pkg::S_E_FETCH;
                if (!ns_fin && (!ns_reach || (relax_d < ns_best))) begin
                    ns_we = 1'b1;
                    ns_wa = ed_tgt;
                    ns_wd = {1'b0, 1'b1, relax_d};
                    if (r_heap_size >= ECW'(MAX_EDGES)) begin
                        n_res_dist = '0;
                        n_res_unr  = 1'b1;
                        n_state    = egsp_pkg::S_Q_DONE;
                    end else begin
                        n_nd        = relax_d;
                        n_nv        = ed_tgt;
                        n_hi        = r_heap_size[EAW-1:0];
                        n_heap_size = r_heap_size + ECW'(1);
                        n_state     = egsp_pkg::S_PU_RD;
                    end
                end
            end
            egsp_pkg::S_PU_RD: begin
                if (r_hi == '0) begin
                    hp_we   = 1'b1;
                    hp_wd   = {r_nd, r_nv};
                    n_state = (r_e == '0) ? egsp_pkg::S_Q_POP : egsp_pkg::S_E_FETCH;
                end else begin
                    hp_re   = 1'b1;
                    hp_raa  = p_idx;
                    n_state = egsp_pkg::S_PU_CMP;
                end
            end
            egsp_pkg::S_PU_CMP: begin
                hp_we = 1'b1;
                if (r_hp_rda[HEW-1 -: DW] <= r_nd) begin
                    hp_wd   = {r_nd, r_nv};
                    n_state = (r_e == '0) ? egsp_pkg::S_Q_POP : egsp_pkg::S_E_FETCH;
                end else begin
                    hp_wd   = r_hp_rda;
                    n_hi    = p_idx;
                    n_state = egsp_pkg::S_PU_RD;
                end
            end
            egsp_pkg::S_Q_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_res_dist;
                    n_out_unr   = r_res_unr;
                    n_state     = egsp_pkg::S_IDLE;
                end
            end
            default: n_state = egsp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_wa] <= {i_req.coord_x, i_req.coord_y};
        end
        if (pt_re) begin
            r_pt_rda <= r_pt_mem[pt_raa];
            r_pt_rdb <= r_pt_mem[pt_rab];
        end
        if (lh_we) begin
            r_lh_mem[lh_wa] <= lh_wd;
        end
        if (lh_re) begin
            r_lh_rd <= r_lh_mem[lh_ra];
        end
        if (ed_we) begin
            r_ed_mem[ed_wa] <= ed_wd;
        end
        if (ed_re) begin
            r_ed_rd <= r_ed_mem[ed_ra];
        end
        if (ns_we) begin
            r_ns_mem[ns_wa] <= ns_wd;
        end
        if (ns_re) begin
            r_ns_rd <= r_ns_mem[ns_ra];
        end
        if (hp_we) begin
            r_hp_mem[hp_wa] <= hp_wd;
        end
        if (hp_re) begin
            r_hp_rda <= r_hp_mem[hp_raa];
            r_hp_rdb <= r_hp_mem[hp_rab];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= egsp_pkg::S_CLR;
            r_cnt        <= '0;
            r_node_count <= '0;
            r_edge_count <= '0;
            r_heap_size  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_edge_count <= n_edge_count;
            r_heap_size  <= n_heap_size;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_prod     <= n_prod;
        r_sq       <= n_sq;
        r_top_dist <= n_top_dist;
        r_top_node <= n_top_node;
        r_last     <= n_last;
        r_hi       <= n_hi;
        r_e        <= n_e;
        r_nd       <= n_nd;
        r_nv       <= n_nv;
        r_res_dist <= n_res_dist;
        r_res_unr  <= n_res_unr;
        r_out_dist <= n_out_dist;
        r_out_unr  <= n_out_unr;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.distance    = r_out_dist;
    assign o_rsp.unreachable = r_out_unr;

`ifndef SYNTHESIS
    a_heap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap_size <= ECW'(MAX_EDGES))
        else $error("heap size beyond capacity");

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_unr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.unreachable) |-> (o_rsp.distance == '0))
        else $error("unreachable result with nonzero distance");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (req_func == egsp_pkg::FUNC_QUERY)) |=> !i_req.ready)
        else $error("request taken during query");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == egsp_pkg::S_E_ROOT))
        else $error("root finished outside edge load");
`endif

endmodule

[rtl/egsp_sqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
// Depends on egsp_pkg for the radicand width.
`timescale 1ns / 1ps

module egsp_sqrt #(
    parameter int FRAC_BITS = egsp_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [egsp_pkg::SQ_W-1:0]    i_sq,
    output logic                         o_done,
    output logic [17+FRAC_BITS-1:0]      o_root
);

    localparam int LW  = 17 + FRAC_BITS;
    localparam int RW  = 2 * LW;
    localparam int RMW = LW + 3;
    localparam int CW  = $clog2(LW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_rad, n_rad;
    logic [RMW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_root, n_root;

    logic [RMW-1:0] rem_s;
    logic [RMW-1:0] trial;

    always_comb begin
        rem_s  = {r_rem[RMW-3:0], r_rad[RW-1 -: 2]};
        trial  = RMW'({r_root, 2'b01});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            // radicand sits in the low bits; the leading pairs are zero
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = RW'(i_sq);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (rem_s >= trial) begin
                n_rem  = rem_s - trial;
                n_root = {r_root[LW-2:0], 1'b1};
            end else begin
                n_rem  = rem_s;
                n_root = {r_root[LW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(LW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[bench/euclidean_graph_shortest_path_unit_tb.sv]
// Self-checking bench for the euclidean graph shortest path unit: directed and
// random point, edge, query and clear transactions, checked against a local model.
// Depends on egsp_pkg, egsp_if and the unit itself.
`timescale 1ns / 1ps

module euclidean_graph_shortest_path_unit_tb;

    localparam int NODES       = 1024;
    localparam int EDGES       = 4096;
    localparam int QUIET_LIMIT = 400000;
    localparam int SETTLE      = 1200;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        egsp_pkg::t_func                func;
        logic [egsp_pkg::NODE_W-1:0]    a;
        logic [egsp_pkg::NODE_W-1:0]    b;
        logic signed [15:0]             x;
        logic signed [15:0]             y;
    } req_item_t;

    typedef struct {
        logic [egsp_pkg::DIST_W-1:0] path_len;
        logic                        unr;
    } path_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [egsp_pkg::CFG_W-1:0] cfg_data = '0;

    egsp_req_if req ();
    egsp_rsp_if rsp ();

    euclidean_graph_shortest_path_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    always #2 clk = ~clk;

    // local copy of the graph state
    int                             nodes_in_use;
    logic signed [15:0]             pt_x [1:NODES];
    logic signed [15:0]             pt_y [1:NODES];
    int                             head [1:NODES];
    int                             e_next [1:EDGES];
    int                             e_tgt [1:EDGES];
    logic [egsp_pkg::DIST_W-1:0]    e_len [1:EDGES];
    int                             e_count;
    logic [egsp_pkg::DIST_W-1:0]    best [1:NODES];
    bit                             done_node [1:NODES];
    bit                             seen_node [1:NODES];
    logic [egsp_pkg::DIST_W-1:0]    hp_d [0:EDGES-1];
    int                             hp_n [0:EDGES-1];
    int                             hp_size;

    req_item_t    pending_reqs [$];
    path_result_t pending_paths [$];
    req_item_t    bus_item;
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_trigger = 0;
    bit           hold_seen = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    // generator bookkeeping
    bit gen_written [1:NODES];
    int gen_points [$];
    int gen_edges;
    int pt_range;

    function automatic logic [egsp_pkg::DIST_W-1:0] fixed_root(logic [63:0] sq);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] pair;
        rem = 0;
        root = 0;
        for (int i = 16 + egsp_pkg::FRAC_BITS_DEF; i >= 0; i--) begin
            pair = (i <= 16) ? ((sq >> (2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root[egsp_pkg::DIST_W-1:0];
    endfunction

    function automatic void heap_push(logic [egsp_pkg::DIST_W-1:0] d, int node);
        int i;
        int p;
        i = hp_size;
        hp_size++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hp_d[p] <= d) break;
            hp_d[i] = hp_d[p];
            hp_n[i] = hp_n[p];
            i = p;
        end
        hp_d[i] = d;
        hp_n[i] = node;
    endfunction

    function automatic void heap_pop(output logic [egsp_pkg::DIST_W-1:0] d, output int node);
        logic [egsp_pkg::DIST_W-1:0] last_d;
        int last_n;
        int i;
        int c;
        d = hp_d[0];
        node = hp_n[0];
        hp_size--;
        last_d = hp_d[hp_size];
        last_n = hp_n[hp_size];
        i = 0;
        forever begin
            c = 2 * i + 1;
            if (c >= hp_size) break;
            if (c + 1 < hp_size && hp_d[c+1] < hp_d[c]) c++;
            if (last_d <= hp_d[c]) break;
            hp_d[i] = hp_d[c];
            hp_n[i] = hp_n[c];
            i = c;
        end
        if (hp_size > 0) begin
            hp_d[i] = last_d;
            hp_n[i] = last_n;
        end
    endfunction

    function automatic void shortest_path(input int s, input int t, input int n,
                                          output bit ok,
                                          output logic [egsp_pkg::DIST_W-1:0] d);
        logic [egsp_pkg::DIST_W-1:0] ud;
        logic [egsp_pkg::DIST_W-1:0] nd;
        logic [egsp_pkg::DIST_W:0]   sum;
        int u;
        int e;
        int v;
        ok = 0;
        d = '0;
        for (int i = 1; i <= n; i++) begin
            done_node[i] = 0;
            seen_node[i] = 0;
            best[i] = '0;
        end
        hp_size = 0;
        seen_node[s] = 1;
        heap_push('0, s);
        while (hp_size > 0) begin
            heap_pop(ud, u);
            // stale entry for a node already settled
            if (done_node[u]) continue;
            done_node[u] = 1;
            if (u == t) begin
                ok = 1;
                d = ud;
                return;
            end
            e = head[u];
            while (e != 0 && e <= EDGES) begin
                v = e_tgt[e];
                if (!(v < 1 || v > n || done_node[v])) begin
                    sum = {1'b0, ud} + {1'b0, e_len[e]};
                    nd = (sum > {1'b0, egsp_pkg::DIST_MAX}) ?
                         egsp_pkg::DIST_MAX : sum[egsp_pkg::DIST_W-1:0];
                    if (!seen_node[v] || nd < best[v]) begin
                        seen_node[v] = 1;
                        best[v] = nd;
                        if (hp_size >= EDGES) return;
                        heap_push(nd, v);
                    end
                end
                e = e_next[e];
            end
        end
    endfunction

    function automatic void predict_item(req_item_t it);
        int a;
        int b;
        int n;
        longint dx;
        longint dy;
        bit ok;
        logic [egsp_pkg::DIST_W-1:0] d;
        path_result_t r;
        a = it.a;
        b = it.b;
        n = (nodes_in_use > NODES) ? NODES : nodes_in_use;
        case (it.func)
            egsp_pkg::FUNC_POINT: begin
                if (a >= 1 && a <= NODES) begin
                    pt_x[a] = it.x;
                    pt_y[a] = it.y;
                end
            end
            egsp_pkg::FUNC_EDGE: begin
                if (a >= 1 && a <= NODES && b >= 1 && b <= NODES && e_count < EDGES) begin
                    dx = longint'(pt_x[a]) - longint'(pt_x[b]);
                    dy = longint'(pt_y[a]) - longint'(pt_y[b]);
                    e_count++;
                    e_tgt[e_count] = b;
                    e_next[e_count] = head[a];
                    e_len[e_count] = fixed_root(64'(dx * dx + dy * dy));
                    head[a] = e_count;
                end
            end
            egsp_pkg::FUNC_CLEAR: begin
                for (int i = 1; i <= NODES; i++) head[i] = 0;
                e_count = 0;
            end
            default: begin
                ok = 0;
                d = '0;
                if (a >= 1 && a <= n && b >= 1 && b <= n) shortest_path(a, b, n, ok, d);
                r.path_len = ok ? d : '0;
                r.unr = !ok;
                pending_paths.push_back(r);
            end
        endcase
    endfunction

    // driver: present pending transactions, apply the model on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            req.valid <= 1'b0;
        end else begin
            if (req.valid && req.ready) predict_item(bus_item);
            if (!req.valid || req.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_item = pending_reqs.pop_front();
                    req.valid   <= 1'b1;
                    req.func    <= bus_item.func;
                    req.node_a  <= bus_item.a;
                    req.node_b  <= bus_item.b;
                    req.coord_x <= bus_item.x;
                    req.coord_y <= bus_item.y;
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk) begin
        path_result_t r;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_paths.size() == 0) begin
                $error("result with nothing outstanding: distance %0d unreachable %0d",
                       rsp.distance, rsp.unreachable);
                err_count++;
            end else begin
                r = pending_paths.pop_front();
                if (rsp.distance !== r.path_len) begin
                    $error("distance: expected %0d actual %0d", r.path_len, rsp.distance);
                    err_count++;
                end
                if (rsp.unreachable !== r.unr) begin
                    $error("unreachable: expected %0d actual %0d", r.unr, rsp.unreachable);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void add_item(egsp_pkg::t_func f, int a, int b, int x, int y);
        req_item_t it;
        it.func = f;
        it.a = a[egsp_pkg::NODE_W-1:0];
        it.b = b[egsp_pkg::NODE_W-1:0];
        it.x = x[15:0];
        it.y = y[15:0];
        if (f == egsp_pkg::FUNC_POINT && a >= 1 && a <= NODES && !gen_written[a]) begin
            gen_written[a] = 1;
            gen_points.push_back(a);
        end
        if (f == egsp_pkg::FUNC_EDGE) gen_edges++;
        if (f == egsp_pkg::FUNC_CLEAR) gen_edges = 0;
        pending_reqs.push_back(it);
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int bad_index();
        return ($urandom_range(1) == 0) ? 0 : int'($urandom_range(2047, NODES + 1));
    endfunction

    function automatic void add_random_item(int n);
        int sel;
        int a;
        int b;
        int nq;
        sel = $urandom_range(99);
        nq = ((n > NODES) ? NODES : n) + 1;
        if (gen_edges > 120 && sel < 40) sel = 99;
        if (sel < 15 || (sel < 55 && gen_points.size() == 0)) begin
            a = ($urandom_range(19) == 0) ? bad_index() : int'($urandom_range(pt_range, 1));
            add_item(egsp_pkg::FUNC_POINT, a, $urandom_range(2047), rand_coord(),
                     rand_coord());
        end else if (sel < 55) begin
            a = gen_points[$urandom_range(gen_points.size() - 1)];
            b = gen_points[$urandom_range(gen_points.size() - 1)];
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) a = bad_index();
                else b = bad_index();
            end
            add_item(egsp_pkg::FUNC_EDGE, a, b, rand_coord(), rand_coord());
        end else if (sel < 98) begin
            a = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(nq, 1));
            b = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(nq, 1));
            add_item(egsp_pkg::FUNC_QUERY, a, b, rand_coord(), rand_coord());
        end else begin
            add_item(egsp_pkg::FUNC_CLEAR, $urandom_range(2047), $urandom_range(2047),
                     rand_coord(), rand_coord());
        end
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req.valid || pending_paths.size() > 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[egsp_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        nodes_in_use = v;
    endtask

    task automatic random_phase(int nc, int range, int count, int s_idle, int r_stall);
        write_node_count(nc);
        pt_range = range;
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        for (int i = 0; i < count; i++) begin
            add_random_item(nc);
            // let everything outstanding return midway through
            if (i == count / 2) wait_drained();
        end
        settle();
    endtask

    initial begin
        req.valid = 1'b0;
        req.func = egsp_pkg::FUNC_POINT;
        req.node_a = '0;
        req.node_b = '0;
        req.coord_x = '0;
        req.coord_y = '0;
        rsp.ready = 1'b0;
        nodes_in_use = 0;
        e_count = 0;
        gen_edges = 0;
        for (int i = 1; i <= NODES; i++) begin
            head[i] = 0;
            gen_written[i] = 0;
            pt_x[i] = '0;
            pt_y[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        // directed: extremes, bad indexes, equal endpoints, unreachable, clear
        write_node_count(NODES);
        add_item(egsp_pkg::FUNC_POINT, 1, 0, -32768, -32768);
        add_item(egsp_pkg::FUNC_POINT, NODES, 2047, 32767, 32767);
        add_item(egsp_pkg::FUNC_POINT, 2, 0, 0, 0);
        add_item(egsp_pkg::FUNC_POINT, 3, 0, 3, 4);
        add_item(egsp_pkg::FUNC_POINT, 0, 0, 5, 5);
        add_item(egsp_pkg::FUNC_POINT, NODES + 1, 0, 5, 5);
        add_item(egsp_pkg::FUNC_POINT, 2047, 0, 5, 5);
        add_item(egsp_pkg::FUNC_EDGE, 1, NODES, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 2, 3, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 3, 1, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 0, 2, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 2, NODES + 1, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, NODES, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, 2, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, NODES, 2, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 0, 2, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, NODES + 1, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2047, 2047, -1, -1);
        add_item(egsp_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, 3, 0, 0);
        settle();

        // edges leaving the node range are skipped
        write_node_count(3);
        add_item(egsp_pkg::FUNC_EDGE, 2, NODES, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, NODES, 3, 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 2, 3, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, 3, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 3, 2, 0, 0);
        add_item(egsp_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        settle();

        random_phase(20, 24, 400, 0, 0);
        random_phase(12, 12, 350, 87, 0);
        random_phase(40, 48, 350, 0, 87);
        hold_trigger = ~hold_trigger;
        random_phase(1, 4, 100, 26, 26);
        random_phase(2047, NODES, 150, 26, 26);
        random_phase(0, 8, 50, 0, 0);

        // dense multigraph on a few nodes, then queries and a clear
        write_node_count(8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_item(egsp_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        for (int i = 1; i <= 4; i++)
            add_item(egsp_pkg::FUNC_POINT, i, 0, rand_coord(), rand_coord());
        for (int i = 0; i < 64; i++)
            add_item(egsp_pkg::FUNC_EDGE, $urandom_range(4, 1), $urandom_range(4, 1), 0, 0);
        add_item(egsp_pkg::FUNC_EDGE, 1, 2, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 1, 4, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 2, 1, 0, 0);
        add_item(egsp_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        add_item(egsp_pkg::FUNC_QUERY, 1, 2, 0, 0);
        settle();

        if (err_count == 0 && pending_paths.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
